FILE: hw/rtl/lkvc_pkg.sv
// Shared constants for the LRU key/value cache.
// No dependencies.
package lkvc_pkg;
  localparam int unsigned KEY_W               = 32;
  localparam int unsigned VAL_W               = 32;
  localparam int unsigned CAP_W               = 5;
  localparam int unsigned DEFAULT_MAX_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET      = 5'd16;
  localparam logic CMD_GET                    = 1'b0;
  localparam logic CMD_PUT                    = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE     = '1;
endpackage

FILE: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and lkvc_store.
//
// Each request (get or put) runs in two phases from acceptance to result: the
// key/value memory is swept one slot per cycle through its single read port to
// find a match, a free slot and the least recent slot, and the done state then
// updates the memories, valid bits and recency ranks once the output register can
// take the result. A new request is accepted while the previous result still waits
// in the output register. Valid bits and the entry count are cleared at reset; no
// clearing pass is needed.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,   // capacity
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,  // key[31:0], value[63:32]
  input  logic             s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // read_value[31:0]
  output logic             m_axis_tuser   // hit
);
  localparam int unsigned IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0]  N_C  = CW'(MAX_ENTRIES);
  localparam logic [CMW-1:0] N_CM = CMW'(MAX_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_e;

  state_e             state_q;
  logic [CAP_W-1:0]   cap_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      cnt_q;
  logic               valid_q [MAX_ENTRIES];
  logic [IW-1:0]      rank_q  [MAX_ENTRIES];
  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic               found_q, lru_ok_q, free_ok_q;
  logic [IW-1:0]      found_idx_q, lru_idx_q, free_idx_q;
  logic [VAL_W-1:0]   found_val_q;
  logic               out_valid_q;
  logic               out_hit_q;
  logic [VAL_W-1:0]   out_val_q;

  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic               rd_en;
  logic [IW-1:0]      p;
  logic               match;
  logic               fire;
  logic [CMW-1:0]     cap_ext, eff_cap;
  logic               full;
  logic [IW-1:0]      tgt;
  logic [IW-1:0]      old_rank;
  logic               newly;
  logic               promote;
  logic               wr_key_en, wr_val_en;

  assign rd_en = (state_q == ST_SCAN) && (cnt_q < N_C);
  assign p     = IW'(cnt_q - CW'(1));
  assign match = valid_q[p] && (rd_key == key_q);
  assign fire  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    cap_ext = CMW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMW'(1);
    end else if (cap_ext > N_CM) begin
      eff_cap = N_CM;
    end else begin
      eff_cap = cap_ext;
    end
    full      = CMW'(count_q) >= eff_cap;
    tgt       = found_idx_q;
    old_rank  = rank_q[found_idx_q];
    newly     = 1'b0;
    promote   = 1'b0;
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    if (found_q) begin
      promote   = 1'b1;
      wr_val_en = (cmd_q == CMD_PUT);
    end else if (cmd_q == CMD_PUT) begin
      if (full) begin
        tgt      = lru_idx_q;
        old_rank = rank_q[lru_idx_q];
        promote  = lru_ok_q;
      end else begin
        tgt      = free_idx_q;
        old_rank = '0;
        newly    = 1'b1;
        promote  = free_ok_q;
      end
      wr_key_en = promote;
      wr_val_en = promote;
    end
  end

  lkvc_store #(
    .Depth (MAX_ENTRIES),
    .IdxW  (IW)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (IW'(cnt_q)),
    .rd_key_o    (rd_key),
    .rd_val_o    (rd_val),
    .wr_key_en_i (fire && wr_key_en),
    .wr_val_en_i (fire && wr_val_en),
    .wr_addr_i   (tgt),
    .wr_key_i    (key_q),
    .wr_val_i    (val_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      lru_ok_q    <= 1'b0;
      free_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q     <= s_axis_tuser;
            key_q     <= s_axis_tdata[31:0];
            val_q     <= s_axis_tdata[63:32];
            cnt_q     <= '0;
            found_q   <= 1'b0;
            lru_ok_q  <= 1'b0;
            free_ok_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q != '0) begin
            if (match && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= p;
              found_val_q <= rd_val;
            end
            if (valid_q[p] && (!lru_ok_q || rank_q[p] > rank_q[lru_idx_q])) begin
              lru_ok_q  <= 1'b1;
              lru_idx_q <= p;
            end
            if (!valid_q[p] && !free_ok_q) begin
              free_ok_q  <= 1'b1;
              free_idx_q <= p;
            end
          end
          if (cnt_q == N_C) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_DONE: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= found_q;
            out_val_q   <= (found_q && cmd_q == CMD_GET) ? found_val_q : MISS_VALUE;
            if (promote) begin
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IW'(i) == tgt) begin
                  rank_q[i] <= '0;
                end else if (valid_q[i] && (newly || rank_q[i] < old_rank)) begin
                  rank_q[i] <= rank_q[i] + IW'(1);
                end
              end
              if (newly) begin
                valid_q[tgt] <= 1'b1;
                count_q      <= count_q + CW'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_hit_q;
endmodule

FILE: hw/rtl/lkvc_store.sv
// Key and value memories of the LRU key/value cache, one read and one write port.
// Depends on lkvc_pkg.
module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int unsigned Depth = DEFAULT_MAX_ENTRIES,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [KEY_W-1:0] rd_key_o,
  output logic [VAL_W-1:0] rd_val_o,
  input  logic             wr_key_en_i,
  input  logic             wr_val_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [KEY_W-1:0] wr_key_i,
  input  logic [VAL_W-1:0] wr_val_i
);
  logic [KEY_W-1:0] key_mem [Depth];
  logic [VAL_W-1:0] val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_key_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_val_en_i) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_val_o <= val_mem[rd_addr_i];
    end
  end
endmodule

FILE: sim/tb_top.sv
// Testbench for lru_key_value_cache: random and directed get/put streams checked
// against an in-bench LRU predictor. Depends on lkvc_pkg and the cache RTL.
`timescale 1ns / 100ps

module tb_top;
  import lkvc_pkg::*;

  localparam int unsigned NSLOT      = DEFAULT_MAX_ENTRIES;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rdata;
  } resp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tuser;

  lru_key_value_cache dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predictor state
  logic             slot_valid [NSLOT];
  logic [KEY_W-1:0] slot_key   [NSLOT];
  logic [VAL_W-1:0] slot_val   [NSLOT];
  int unsigned      slot_age   [NSLOT];
  int unsigned      used_slots;
  logic [CAP_W-1:0] cap_reg;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    send_idle_pct, recv_idle_pct;
  int    errors = 0;
  int    idle_cycles = 0;
  bit    recv_hold;

  // acceptance seen at the last rising edge
  logic s_axis_tready_q = 1'b0;

  function automatic int unsigned cap_effective();
    if (cap_reg == 0) return 1;
    if (cap_reg > NSLOT) return NSLOT;
    return cap_reg;
  endfunction

  function automatic void touch(int s, int unsigned old_age, bit fresh);
    for (int i = 0; i < NSLOT; i++)
      if (i != s && slot_valid[i] && (fresh || slot_age[i] < old_age))
        slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic resp_t lookup_and_update(req_t r);
    resp_t rsp;
    int    hit_slot, victim;
    hit_slot = -1;
    victim   = -1;
    for (int i = 0; i < NSLOT; i++)
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == r.key) hit_slot = i;
    rsp.hit   = (hit_slot >= 0);
    rsp.rdata = MISS_VALUE;
    if (hit_slot >= 0) begin
      if (r.cmd == CMD_GET) rsp.rdata = slot_val[hit_slot];
      else slot_val[hit_slot] = r.val;
      touch(hit_slot, slot_age[hit_slot], 1'b0);
    end else if (r.cmd == CMD_PUT) begin
      if (used_slots >= cap_effective()) begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        slot_key[victim] = r.key;
        slot_val[victim] = r.val;
        touch(victim, slot_age[victim], 1'b0);
      end else begin
        for (int i = 0; i < NSLOT; i++)
          if (victim < 0 && !slot_valid[i]) victim = i;
        slot_key[victim] = r.key;
        slot_val[victim] = r.val;
        touch(victim, 0, 1'b1);
        slot_valid[victim] = 1'b1;
        used_slots++;
      end
    end
    return rsp;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || s_axis_tready_q) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_reqs[0].cmd;
        s_axis_tdata  <= {pending_reqs[0].val, pending_reqs[0].key};
        void'(pending_reqs.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready)
      expected_resps.push_back(lookup_and_update('{s_axis_tuser, s_axis_tdata[31:0],
                                                   s_axis_tdata[63:32]}));
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("FAIL");
        $finish;
      end
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result hit=%0b value=%h", $realtime, m_axis_tuser,
                 m_axis_tdata);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        if (want.hit !== m_axis_tuser) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, m_axis_tuser);
          errors++;
        end
        if (want.rdata !== m_axis_tdata) begin
          $display("%0t: read_value expected %h actual %h", $realtime, want.rdata,
                   m_axis_tdata);
          errors++;
        end
      end
    end
  end

  task automatic queue_req(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    req_t r;
    r.cmd = cmd;
    r.key = key;
    r.val = val;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (3 * NSLOT) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = c;
  endtask

  // random traffic over a small key pool so that hits and evictions are common
  task automatic random_burst(int n, int pool);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) k = $urandom();
      else k = 32'h7FFF_FFF0 + $urandom_range(pool - 1);
      queue_req(logic'($urandom_range(1)), k, $urandom());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [6];
    caps = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd9};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    cap_reg = CAP_RESET;
    used_slots = 0;
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
      slot_age[i]   = 0;
    end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, both commands, update, miss, eviction
    queue_req(CMD_GET, 32'h8000_0000, 32'h0);
    queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    queue_req(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h0);
    queue_req(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 17; i++) queue_req(CMD_PUT, 32'h100 + i, i);
    drain();
    // capacity lowered below the count: inserts replace, count stays
    set_capacity(5'd2);
    queue_req(CMD_PUT, 32'hABCD, 32'h1);
    queue_req(CMD_GET, 32'h110, 32'h0);
    queue_req(CMD_GET, 32'h101, 32'h0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 19 : 0;
      for (int c = 0; c < 2; c++) begin
        set_capacity(caps[ph * 2 + c]);
        random_burst(180, (c == 0) ? 6 : 24);
        if (ph == 0 && c == 0) begin
          while (pending_reqs.size() > 150) @(posedge clk_i);
          recv_hold = 1'b1;
          repeat (200) @(posedge clk_i);
          recv_hold = 1'b0;
        end
        drain();
      end
    end

    if (errors == 0 && expected_resps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: lru_key_value_cache.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_store.sv
hw/rtl/lru_key_value_cache.sv
sim/tb_top.sv
